FILE: rtl/assert_macros.svh
// assertion macros shared by the priority queue rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpq assertion failed");

// antecedent implies consequent in the next cycle
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpq assertion failed");

// property holds at every edge out of reset
`define MPQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mpq assertion failed");

`endif

FILE: rtl/mpq_pkg.sv
// types and constants for the max priority queue with fifo ties
// no dependencies
package mpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int MAX_BURST = 64;
    localparam int VAL_W     = 32;
    localparam int SEQ_W     = 16;
    localparam int CNT_W     = 7;
    localparam int OCC_W     = $clog2(CAPACITY + 1);

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_SERVE   = 1'b1;

    localparam logic STAT_SERVED  = 1'b0;
    localparam logic STAT_DROPPED = 1'b1;

    typedef enum logic
    {
        ST_IDLE  = 1'b0,
        ST_SERVE = 1'b1
    } mpq_state_t;

    typedef struct packed
    {
        logic             req_type;
        logic [VAL_W-1:0] arrival_value;
        logic [CNT_W-1:0] serve_count;
    } mpq_req_t;

    typedef struct packed
    {
        logic [SEQ_W-1:0] entry_seq;
        logic [VAL_W-1:0] entry_value;
        logic             status;
        logic             last_of_run;
    } mpq_res_t;

    // controller to datapath
    typedef struct packed
    {
        logic insert;
        logic pop;
        logic last;
    } mpq_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic [CNT_W-1:0] burst_len;
    } mpq_stat_t;

endpackage

FILE: rtl/max_priority_queue_fifo_ties.sv
// max priority queue, fifo order among equal values, 1024 entries.
// arrival: busy stays low; a dropped arrival's result appears next cycle.
// serve of n entries: busy while serving, one result per cycle from the cell chain head,
// first result the cycle after the first pop; next item accepted after the last pop.
// reset (rst_n low, async) empties the queue and zeroes the arrival number.
// results are strobed for one cycle; the receiver cannot stall them.
module max_priority_queue_fifo_ties
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mpq_pkg::mpq_req_t item,
    output logic             busy,
    output logic             strobe,
    output mpq_pkg::mpq_res_t result
);
    import mpq_pkg::*;

    mpq_cmd_t  cmd;
    mpq_stat_t stat;

    // controller
    mpq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath
    mpq_chain u_chain
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .strobe (strobe),
        .result (result)
    );

endmodule

FILE: rtl/mpq_chain.sv
// datapath: sorted cell chain, occupancy, arrival numbering, result register
// depends on mpq_pkg and assert_macros.svh
module mpq_chain
(
    input  logic              clk,
    input  logic              rst_n,
    input  mpq_pkg::mpq_req_t item,
    input  mpq_pkg::mpq_cmd_t cmd,
    output mpq_pkg::mpq_stat_t stat,
    output logic              strobe,
    output mpq_pkg::mpq_res_t result
);
    import mpq_pkg::*;

    `include "assert_macros.svh"

    logic [VAL_W-1:0] val_reg [CAPACITY];
    logic [SEQ_W-1:0] seq_reg [CAPACITY];
    logic [CAPACITY-1:0] keep;
    logic [OCC_W-1:0] occ_reg;
    logic [SEQ_W-1:0] next_seq_reg;
    logic             strobe_reg;
    mpq_res_t         result_reg;
    logic             full;
    logic             ins_ok;
    logic [CNT_W-1:0] sat_count;

    assign full   = (occ_reg == OCC_W'(CAPACITY));
    assign ins_ok = cmd.insert && !full;

    // cells that stay ahead of the new entry (greater or equal value)
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep[i] = (OCC_W'(i) < occ_reg) && (val_reg[i] >= item.arrival_value);
        end
    end

    // burst length: request saturated, then limited by occupancy
    always_comb
    begin
        sat_count = (item.serve_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                           : item.serve_count;
        if (occ_reg < OCC_W'(sat_count))
            stat.burst_len = occ_reg[CNT_W-1:0];
        else
            stat.burst_len = sat_count;
    end

    // cell chain: insert shifts the tail right, pop shifts all but the last cell left
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (ins_ok && !keep[i])
            begin
                if (i == 0)
                begin
                    val_reg[i] <= item.arrival_value;
                    seq_reg[i] <= next_seq_reg;
                end
                else if (keep[(i == 0) ? 0 : i-1])
                begin
                    val_reg[i] <= item.arrival_value;
                    seq_reg[i] <= next_seq_reg;
                end
                else
                begin
                    val_reg[i] <= val_reg[(i == 0) ? 0 : i-1];
                    seq_reg[i] <= seq_reg[(i == 0) ? 0 : i-1];
                end
            end
            else if (cmd.pop && (i < CAPACITY-1))
            begin
                val_reg[i] <= val_reg[(i < CAPACITY-1) ? i+1 : i];
                seq_reg[i] <= seq_reg[(i < CAPACITY-1) ? i+1 : i];
            end
        end
    end

    // occupancy and arrival numbering
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            next_seq_reg <= '0;
        end
        else
        begin
            if (cmd.insert)
                next_seq_reg <= next_seq_reg + SEQ_W'(1);
            if (ins_ok)
                occ_reg <= occ_reg + OCC_W'(1);
            else if (cmd.pop)
                occ_reg <= occ_reg - OCC_W'(1);
        end
    end

    // result transfer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.pop || (cmd.insert && full);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            result_reg.entry_seq   <= seq_reg[0];
            result_reg.entry_value <= val_reg[0];
            result_reg.status      <= STAT_SERVED;
            result_reg.last_of_run <= cmd.last;
        end
        else if (cmd.insert && full)
        begin
            result_reg.entry_seq   <= next_seq_reg;
            result_reg.entry_value <= item.arrival_value;
            result_reg.status      <= STAT_DROPPED;
            result_reg.last_of_run <= 1'b1;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `MPQ_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg <= OCC_W'(CAPACITY))
    `MPQ_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, cmd.pop, occ_reg != '0)
    `MPQ_ASSERT_NEXT(a_drop_strobe, clk, rst_n, cmd.insert && full, strobe_reg && result_reg.status == STAT_DROPPED)

endmodule

FILE: rtl/mpq_ctrl.sv
// controller: accepts items and sequences serve bursts one pop per cycle
// depends on mpq_pkg and assert_macros.svh
module mpq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mpq_pkg::mpq_req_t  item,
    input  mpq_pkg::mpq_stat_t stat,
    output mpq_pkg::mpq_cmd_t  cmd,
    output logic               busy
);
    import mpq_pkg::*;

    `include "assert_macros.svh"

    mpq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] rem_reg, rem_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.req_type == REQ_ARRIVAL)
                        cmd.insert = 1'b1;
                    else if (stat.burst_len != '0)
                    begin
                        rem_next   = stat.burst_len;
                        state_next = ST_SERVE;
                    end
                end
            end
            ST_SERVE:
            begin
                busy     = 1'b1;
                cmd.pop  = 1'b1;
                cmd.last = (rem_reg == CNT_W'(1));
                rem_next = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `MPQ_ASSERT_IMPL(a_serve_rem, clk, rst_n, state_reg == ST_SERVE, rem_reg != '0)
    `MPQ_ASSERT_NEXT(a_last_idle, clk, rst_n, cmd.pop && cmd.last, state_reg == ST_IDLE)
    `MPQ_ASSERT_IMPL(a_busy_serve, clk, rst_n, busy, state_reg == ST_SERVE)

endmodule

FILE: tb/max_priority_queue_fifo_ties_tb.sv
// testbench for the max priority queue with fifo ties: directed table, random mix
// depends on mpq_pkg and max_priority_queue_fifo_ties
`timescale 1ns / 1ps

module max_priority_queue_fifo_ties_tb;
    import mpq_pkg::*;

    typedef struct packed
    {
        logic [VAL_W-1:0] value;
        logic [SEQ_W-1:0] seq;
    } held_entry_t;

    typedef struct
    {
        mpq_req_t req;
        bit       known;
        mpq_res_t res;
    } table_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    mpq_req_t  item;
    logic      busy;
    logic      strobe;
    mpq_res_t  result;

    // predictor state and outstanding expectations
    held_entry_t      held_entries[$];
    logic [SEQ_W-1:0] next_arrival_seq;
    mpq_res_t         pending_results[$];
    mpq_res_t         last_seen;
    int               fail_count;
    int               result_count;
    int               drop_count;
    int               transfer_count;

    table_row_t directed_rows[$];

    max_priority_queue_fifo_ties dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    // clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // work out the results that one accepted transfer causes
    task automatic predict_queue_step(input mpq_req_t req);
        int pos;
        int n;
        held_entry_t e;
        mpq_res_t r;
        begin
            if (req.req_type == REQ_ARRIVAL)
            begin
                e.value = req.arrival_value;
                e.seq   = next_arrival_seq;
                next_arrival_seq = next_arrival_seq + 1'b1;
                if (held_entries.size() >= CAPACITY)
                begin
                    r.entry_seq   = e.seq;
                    r.entry_value = e.value;
                    r.status      = STAT_DROPPED;
                    r.last_of_run = 1'b1;
                    pending_results.push_back(r);
                end
                else
                begin
                    // new entry goes behind every entry with greater or equal value
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].value >= e.value)
                        pos++;
                    held_entries.insert(pos, e);
                end
            end
            else
            begin
                n = int'(req.serve_count);
                if (n > MAX_BURST)
                    n = MAX_BURST;
                if (n > held_entries.size())
                    n = held_entries.size();
                for (int k = 0; k < n; k++)
                begin
                    e = held_entries.pop_front();
                    r.entry_seq   = e.seq;
                    r.entry_value = e.value;
                    r.status      = STAT_SERVED;
                    r.last_of_run = (k == n - 1);
                    pending_results.push_back(r);
                end
            end
        end
    endtask

    // compare results and predict on every accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            last_seen = result;
            result_count++;
            if (result.status == STAT_DROPPED)
                drop_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result seq=%0d value=%0h", result.entry_seq,
                       result.entry_value);
                fail_count++;
            end
            else
            begin
                mpq_res_t want;
                want = pending_results.pop_front();
                if (result.entry_seq !== want.entry_seq)
                begin
                    $error("entry_seq expected %0d actual %0d", want.entry_seq,
                           result.entry_seq);
                    fail_count++;
                end
                if (result.entry_value !== want.entry_value)
                begin
                    $error("entry_value expected %0h actual %0h", want.entry_value,
                           result.entry_value);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status expected %0b actual %0b", want.status, result.status);
                    fail_count++;
                end
                if (result.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run expected %0b actual %0b", want.last_of_run,
                           result.last_of_run);
                    fail_count++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            transfer_count++;
            predict_queue_step(item);
        end
    end

    // random gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    // drive one transfer from a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input mpq_req_t req, input int gap);
        begin
            if (gap > 0)
            begin
                start <= 1'b0;
                item  <= mpq_req_t'(40'({$urandom, $urandom}));
                repeat (gap) @(negedge clk);
            end
            start <= 1'b1;
            item  <= req;
            do
                @(posedge clk);
            while (busy);
            @(negedge clk);
        end
    endtask

    function automatic mpq_req_t make_arrival(input logic [VAL_W-1:0] v);
        mpq_req_t q;
        begin
            q.req_type      = REQ_ARRIVAL;
            q.arrival_value = v;
            q.serve_count   = CNT_W'($urandom);
            return q;
        end
    endfunction

    function automatic mpq_req_t make_serve(input logic [CNT_W-1:0] c);
        mpq_req_t q;
        begin
            q.req_type      = REQ_SERVE;
            q.arrival_value = $urandom;
            q.serve_count   = c;
            return q;
        end
    endfunction

    // let the block settle until every expected result has come
    task automatic wait_drained();
        begin
            start <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            @(negedge clk);
        end
    endtask

    function automatic void add_row(input mpq_req_t req, input bit known,
                                    input logic [SEQ_W-1:0] s, input logic [VAL_W-1:0] v);
        table_row_t row;
        begin
            row.req = req;
            row.known = known;
            row.res.entry_seq = s;
            row.res.entry_value = v;
            row.res.status = STAT_SERVED;
            row.res.last_of_run = 1'b1;
            directed_rows.push_back(row);
        end
    endfunction

    initial
    begin
        mpq_req_t q;
        int r;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        fail_count = 0;
        result_count = 0;
        drop_count = 0;
        transfer_count = 0;
        next_arrival_seq = '0;
        last_seen = '0;

        // directed table: empty serves, extremes, saturation, ties
        add_row(make_serve(7'd1), 1'b0, '0, '0);
        add_row(make_serve(7'd0), 1'b0, '0, '0);
        add_row(make_arrival(32'hFFFF_FFFF), 1'b0, '0, '0);
        add_row(make_serve(7'd1), 1'b1, 16'd0, 32'hFFFF_FFFF);
        add_row(make_arrival(32'h0), 1'b0, '0, '0);
        add_row(make_serve(7'd127), 1'b1, 16'd1, 32'h0);
        add_row(make_arrival(32'd5), 1'b0, '0, '0);
        add_row(make_arrival(32'd5), 1'b0, '0, '0);
        add_row(make_arrival(32'd9), 1'b0, '0, '0);
        add_row(make_arrival(32'd5), 1'b0, '0, '0);
        add_row(make_arrival(32'h0), 1'b0, '0, '0);
        add_row(make_arrival(32'hFFFF_FFFF), 1'b0, '0, '0);
        add_row(make_arrival(32'hAAAA_5555), 1'b0, '0, '0);
        add_row(make_serve(7'd3), 1'b0, '0, '0);
        add_row(make_serve(7'd0), 1'b0, '0, '0);
        add_row(make_serve(7'd64), 1'b0, '0, '0);
        add_row(make_serve(7'd2), 1'b0, '0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req, 0);
            if (directed_rows[i].known)
            begin
                wait_drained();
                if (last_seen !== directed_rows[i].res)
                begin
                    $error("table row %0d expected %0h actual %0h", i,
                           directed_rows[i].res, last_seen);
                    fail_count++;
                end
            end
        end
        wait_drained();

        // random mix with a small, changing queue
        for (int i = 0; i < 250; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 62)
            begin
                if ($urandom_range(0, 2) == 0)
                    q = make_arrival($urandom);
                else
                    q = make_arrival($urandom_range(0, 7));
            end
            else if (r < 92)
                q = make_serve(CNT_W'($urandom_range(1, 8)));
            else if (r < 97)
                q = make_serve(CNT_W'($urandom_range(0, 127)));
            else
                q = make_serve(7'd0);
            // stretches with no idling
            send_request(q, ((i / 40) % 3 == 1) ? 0 : pick_gap());
        end
        while (held_entries.size() != 0)
            send_request(make_serve(CNT_W'($urandom_range(1, 64))), pick_gap());
        wait_drained();

        $display("covered %0d transfers, %0d results (%0d drops), ties, bursts and idle gaps",
                 transfer_count, result_count, drop_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
